@@ rtl/rddh_pkg.sv @@
// Shared types and constants for the register dependency distance histogram.
// No dependencies; used by rddh_ctrl, rddh_datapath and the top level.
package rddh_pkg;

   // Table and counter geometry
   localparam int NUM_REGS    = 256;
   localparam int REG_BITS    = 8;
   localparam int STAMP_BITS  = 48;
   localparam int INSTR_BITS  = 48;
   localparam int CNT_BITS    = 32;
   localparam int EDGE_BITS   = 8;
   localparam int NUM_BINS    = 12;
   localparam int BIN_IDX_BITS = $clog2(NUM_BINS);

   // Operand modes
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_END   = 2'd2;

   // Dependency kinds
   localparam logic [1:0] DEP_NONE = 2'd0;
   localparam logic [1:0] DEP_RAW  = 2'd1;
   localparam logic [1:0] DEP_WAR  = 2'd2;
   localparam logic [1:0] DEP_WAW  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_BIN_EDGE_LOW  = 2'd0;
   localparam logic [1:0] CSR_BIN_EDGE_MID  = 2'd1;
   localparam logic [1:0] CSR_BIN_EDGE_HIGH = 2'd2;

   // Edge reset values
   localparam logic [EDGE_BITS-1:0] EDGE_LOW_RST  = 8'd2;
   localparam logic [EDGE_BITS-1:0] EDGE_MID_RST  = 8'd8;
   localparam logic [EDGE_BITS-1:0] EDGE_HIGH_RST = 8'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIST,
      ST_BIN,
      ST_COMMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic distance;
      logic bin;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ rtl/register_dependency_distance_histogram.sv @@
// Register dependency distance histogram, top level.
// An accepted request beat passes the stamp memory read, the distance subtract,
// the bin compare and the counter commit in turn before its response beat;
// commit waits for a held response, and no new request is taken until the commit is done.
// Reset clears pending bits, bin and instruction counters and restores the edges;
// stamp memories are not cleared and need no clearing pass.
module register_dependency_distance_histogram (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [rddh_pkg::REG_BITS-1:0]   req_reg_id,
   input  logic                            req_is_fp,
   input  logic                            req_is_int,
   input  logic                            csr_write_en,
   input  logic [1:0]                      csr_index,
   input  logic [rddh_pkg::EDGE_BITS-1:0]  csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_dep_kind,
   output logic [1:0]                      rsp_dist_bin,
   output logic [rddh_pkg::CNT_BITS-1:0]   rsp_bin_count,
   output logic [rddh_pkg::INSTR_BITS-1:0] rsp_instr_count,
   output logic [rddh_pkg::CNT_BITS-1:0]   rsp_int_instr_count,
   output logic [rddh_pkg::CNT_BITS-1:0]   rsp_fp_instr_count
);

   rddh_pkg::cmd_type    cmd;
   rddh_pkg::status_type status;

   rddh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rddh_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_reg_id          (req_reg_id),
      .req_is_fp           (req_is_fp),
      .req_is_int          (req_is_int),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_dep_kind        (rsp_dep_kind),
      .rsp_dist_bin        (rsp_dist_bin),
      .rsp_bin_count       (rsp_bin_count),
      .rsp_instr_count     (rsp_instr_count),
      .rsp_int_instr_count (rsp_int_instr_count),
      .rsp_fp_instr_count  (rsp_fp_instr_count)
   );

   // One item in flight: no new request beat right after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // A response with no dependency carries no bin and no count
   a_none_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dep_kind == rddh_pkg::DEP_NONE |->
         rsp_dist_bin == 2'd0 && rsp_bin_count == '0)
      else $error("empty dependency with bin data");

   // A hit bin count is at least one after its increment
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dep_kind != rddh_pkg::DEP_NONE |-> rsp_bin_count != '0)
      else $error("dependency reported with zero count");

   // Instruction count never goes backward between responses
   a_instr_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> rsp_instr_count >= $past(rsp_instr_count))
      else $error("instruction count decreased");

endmodule

@@ rtl/rddh_ctrl.sv @@
// Sequencer for the dependency histogram: capture, distance, bin, commit.
// Depends on rddh_pkg.
module rddh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rddh_pkg::status_type status,
   output rddh_pkg::cmd_type    cmd
);

   rddh_pkg::state_type state_ff;
   rddh_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rddh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rddh_pkg::ST_IDLE: begin
            if (req_valid) state_in = rddh_pkg::ST_DIST;
         end
         rddh_pkg::ST_DIST:   state_in = rddh_pkg::ST_BIN;
         rddh_pkg::ST_BIN:    state_in = rddh_pkg::ST_COMMIT;
         rddh_pkg::ST_COMMIT: begin
            // hold until the result register can take the beat
            if (status.out_free) state_in = rddh_pkg::ST_IDLE;
         end
         default: state_in = rddh_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         rddh_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         rddh_pkg::ST_DIST:   cmd.distance = 1'b1;
         rddh_pkg::ST_BIN:    cmd.bin      = 1'b1;
         rddh_pkg::ST_COMMIT: cmd.commit   = status.out_free;
         default: ;
      endcase
   end

endmodule

@@ rtl/rddh_datapath.sv @@
// Datapath: pending bits, stamp memories, bin edges, counters, result register.
// Depends on rddh_pkg; driven by rddh_ctrl.
module rddh_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rddh_pkg::cmd_type                   cmd,
   output rddh_pkg::status_type                status,
   input  logic [1:0]                          req_mode,
   input  logic [rddh_pkg::REG_BITS-1:0]       req_reg_id,
   input  logic                                req_is_fp,
   input  logic                                req_is_int,
   input  logic                                csr_write_en,
   input  logic [1:0]                          csr_index,
   input  logic [rddh_pkg::EDGE_BITS-1:0]      csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_dep_kind,
   output logic [1:0]                          rsp_dist_bin,
   output logic [rddh_pkg::CNT_BITS-1:0]       rsp_bin_count,
   output logic [rddh_pkg::INSTR_BITS-1:0]     rsp_instr_count,
   output logic [rddh_pkg::CNT_BITS-1:0]       rsp_int_instr_count,
   output logic [rddh_pkg::CNT_BITS-1:0]       rsp_fp_instr_count
);

   localparam int RB = rddh_pkg::REG_BITS;
   localparam int SB = rddh_pkg::STAMP_BITS;
   localparam int IB = rddh_pkg::INSTR_BITS;
   localparam int CB = rddh_pkg::CNT_BITS;
   localparam int EB = rddh_pkg::EDGE_BITS;
   localparam int XB = rddh_pkg::BIN_IDX_BITS;

   // Stamp memories (no reset; only used while the pending bit is set)
   logic [SB-1:0] rstamp_mem [rddh_pkg::NUM_REGS];
   logic [SB-1:0] wstamp_mem [rddh_pkg::NUM_REGS];

   logic [rddh_pkg::NUM_REGS-1:0] rpend_ff, rpend_in;
   logic [rddh_pkg::NUM_REGS-1:0] wpend_ff, wpend_in;

   // Captured item
   logic [1:0]    mode_ff;
   logic [RB-1:0] reg_ff;
   logic          fp_ff;
   logic          int_ff;
   logic          in_range_ff;
   logic          rp_ff;
   logic          wp_ff;
   logic [SB-1:0] rstamp_ff;
   logic [SB-1:0] wstamp_ff;

   // Stage registers
   logic [1:0]    kind_ff, kind_in;
   logic [SB-1:0] dist_ff, dist_in;
   logic [1:0]    bin_ff, bin_in;
   logic [XB-1:0] idx_ff, idx_in;

   logic [EB-1:0] edge_low_ff, edge_mid_ff, edge_high_ff;

   logic [CB-1:0] bin_cnt_ff [rddh_pkg::NUM_BINS];
   logic [IB-1:0] instr_ff, instr_in;
   logic [CB-1:0] int_cnt_ff, int_cnt_in;
   logic [CB-1:0] fp_cnt_ff, fp_cnt_in;
   logic          saw_fp_ff, saw_fp_in;
   logic          saw_int_ff, saw_int_in;
   logic [CB-1:0] hit_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;

   logic [SB-1:0] now;
   logic          is_access;

   assign now       = instr_ff[SB-1:0];
   assign is_access = (mode_ff == rddh_pkg::MODE_READ) || (mode_ff == rddh_pkg::MODE_WRITE);

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_low_ff  <= rddh_pkg::EDGE_LOW_RST;
         edge_mid_ff  <= rddh_pkg::EDGE_MID_RST;
         edge_high_ff <= rddh_pkg::EDGE_HIGH_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            rddh_pkg::CSR_BIN_EDGE_LOW:  edge_low_ff  <= csr_write_data;
            rddh_pkg::CSR_BIN_EDGE_MID:  edge_mid_ff  <= csr_write_data;
            rddh_pkg::CSR_BIN_EDGE_HIGH: edge_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Capture the beat and read both stamp memories
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         reg_ff      <= req_reg_id;
         fp_ff       <= req_is_fp;
         int_ff      <= req_is_int;
         in_range_ff <= ({1'b0, req_reg_id} < (RB+1)'(rddh_pkg::NUM_REGS));
         rp_ff       <= rpend_ff[req_reg_id];
         wp_ff       <= wpend_ff[req_reg_id];
         rstamp_ff   <= rstamp_mem[req_reg_id];
         wstamp_ff   <= wstamp_mem[req_reg_id];
      end
   end

   // Dependency kind and distance
   always_comb begin
      kind_in = rddh_pkg::DEP_NONE;
      dist_in = now - wstamp_ff;
      if (in_range_ff) begin
         if (mode_ff == rddh_pkg::MODE_READ) begin
            if (wp_ff) kind_in = rddh_pkg::DEP_RAW;
         end else if (mode_ff == rddh_pkg::MODE_WRITE) begin
            if (rp_ff) begin
               kind_in = rddh_pkg::DEP_WAR;
               dist_in = now - rstamp_ff;
            end else if (wp_ff) begin
               kind_in = rddh_pkg::DEP_WAW;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.distance) begin
         kind_ff <= kind_in;
         dist_ff <= dist_in;
      end
   end

   // Bin selection against the edges
   always_comb begin
      if (dist_ff > SB'(edge_high_ff))     bin_in = 2'd3;
      else if (dist_ff > SB'(edge_mid_ff)) bin_in = 2'd2;
      else if (dist_ff > SB'(edge_low_ff)) bin_in = 2'd1;
      else                                 bin_in = 2'd0;
      idx_in = XB'({kind_ff - 2'd1, bin_in});
   end

   always_ff @(posedge clock) begin
      if (cmd.bin) begin
         bin_ff <= bin_in;
         idx_ff <= idx_in;
      end
   end

   // Next counter values at commit
   always_comb begin
      hit_cnt_in = bin_cnt_ff[idx_ff];
      if (hit_cnt_in != '1) hit_cnt_in = hit_cnt_in + CB'(1);

      instr_in   = instr_ff;
      int_cnt_in = int_cnt_ff;
      fp_cnt_in  = fp_cnt_ff;
      saw_fp_in  = saw_fp_ff;
      saw_int_in = saw_int_ff;
      if (is_access) begin
         saw_fp_in  = saw_fp_ff | fp_ff;
         saw_int_in = saw_int_ff | int_ff;
      end else if (mode_ff == rddh_pkg::MODE_END) begin
         if (saw_fp_ff && fp_cnt_ff != '1)   fp_cnt_in  = fp_cnt_ff + CB'(1);
         if (saw_int_ff && int_cnt_ff != '1) int_cnt_in = int_cnt_ff + CB'(1);
         if (instr_ff != '1)                 instr_in   = instr_ff + IB'(1);
         saw_fp_in  = 1'b0;
         saw_int_in = 1'b0;
      end
   end

   // Pending bit updates
   always_comb begin
      rpend_in = rpend_ff;
      wpend_in = wpend_ff;
      if (in_range_ff) begin
         if (mode_ff == rddh_pkg::MODE_READ) begin
            rpend_in[reg_ff] = 1'b1;
            if (kind_ff == rddh_pkg::DEP_RAW) wpend_in[reg_ff] = 1'b0;
         end else if (mode_ff == rddh_pkg::MODE_WRITE) begin
            wpend_in[reg_ff] = 1'b1;
            if (kind_ff == rddh_pkg::DEP_WAR) rpend_in[reg_ff] = 1'b0;
         end
      end
   end

   // Control state: pending bits, counters, flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rpend_ff   <= '0;
         wpend_ff   <= '0;
         instr_ff   <= '0;
         int_cnt_ff <= '0;
         fp_cnt_ff  <= '0;
         saw_fp_ff  <= 1'b0;
         saw_int_ff <= 1'b0;
         for (int i = 0; i < rddh_pkg::NUM_BINS; i++) bin_cnt_ff[i] <= '0;
      end else if (cmd.commit) begin
         rpend_ff   <= rpend_in;
         wpend_ff   <= wpend_in;
         instr_ff   <= instr_in;
         int_cnt_ff <= int_cnt_in;
         fp_cnt_ff  <= fp_cnt_in;
         saw_fp_ff  <= saw_fp_in;
         saw_int_ff <= saw_int_in;
         if (kind_ff != rddh_pkg::DEP_NONE) bin_cnt_ff[idx_ff] <= hit_cnt_in;
      end
   end

   // Stamp memory writes
   always_ff @(posedge clock) begin
      if (cmd.commit && in_range_ff) begin
         if (mode_ff == rddh_pkg::MODE_READ)  rstamp_mem[reg_ff] <= now;
         if (mode_ff == rddh_pkg::MODE_WRITE) wstamp_mem[reg_ff] <= now;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_dep_kind        <= kind_ff;
         rsp_dist_bin        <= (kind_ff == rddh_pkg::DEP_NONE) ? 2'd0 : bin_ff;
         rsp_bin_count       <= (kind_ff == rddh_pkg::DEP_NONE) ? '0 : hit_cnt_in;
         rsp_instr_count     <= instr_in;
         rsp_int_instr_count <= int_cnt_in;
         rsp_fp_instr_count  <= fp_cnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for register_dependency_distance_histogram.
// Depends on rddh_pkg and the top level; drives operand beats and checks every response
// against hand-set rows or an in-file predictor of the dependency tables, bins and instruction counters.
module testbench;
   import rddh_pkg::*;

   localparam logic [1:0] MODE_UNUSED      = 2'd3;
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam bit         TYPED            = 1'b1;
   localparam bit         FROM_MODEL       = 1'b0;
   localparam int         NUM_PHASES       = 6;
   localparam int         ITEMS_PER_PHASE  = 175;
   localparam int         POOL_SIZE        = 24;
   localparam int         SETTLE_CYCLES    = 16;
   localparam int         QUIET_LIMIT      = 4000;
   localparam int         MAX_PRINTED      = 40;

   typedef struct packed {
      logic [1:0]          mode;
      logic [REG_BITS-1:0] reg_id;
      logic                is_fp;
      logic                is_int;
   } operand_t;

   typedef struct packed {
      logic [1:0]            dep_kind;
      logic [1:0]            dist_bin;
      logic [CNT_BITS-1:0]   bin_count;
      logic [INSTR_BITS-1:0] instr_count;
      logic [CNT_BITS-1:0]   int_count;
      logic [CNT_BITS-1:0]   fp_count;
   } bin_update_t;

   typedef struct packed {
      operand_t    op;
      bit          typed;
      bin_update_t want;
   } stim_row_t;

   // DUT connections; the inputs that the bench drives are known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_mode = MODE_END;
   logic [REG_BITS-1:0]   req_reg_id = '0;
   logic                  req_is_fp = 1'b0;
   logic                  req_is_int = 1'b0;
   logic                  csr_write_en = 1'b0;
   logic [1:0]            csr_index = CSR_BIN_EDGE_LOW;
   logic [EDGE_BITS-1:0]  csr_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_dep_kind;
   logic [1:0]            rsp_dist_bin;
   logic [CNT_BITS-1:0]   rsp_bin_count;
   logic [INSTR_BITS-1:0] rsp_instr_count;
   logic [CNT_BITS-1:0]   rsp_int_instr_count;
   logic [CNT_BITS-1:0]   rsp_fp_instr_count;

   // Predictor state
   logic [EDGE_BITS-1:0]  edge_low  = EDGE_LOW_RST;
   logic [EDGE_BITS-1:0]  edge_mid  = EDGE_MID_RST;
   logic [EDGE_BITS-1:0]  edge_high = EDGE_HIGH_RST;
   logic                  rd_pending [NUM_REGS];
   logic [STAMP_BITS-1:0] rd_stamp   [NUM_REGS];
   logic                  wr_pending [NUM_REGS];
   logic [STAMP_BITS-1:0] wr_stamp   [NUM_REGS];
   logic [CNT_BITS-1:0]   bin_tally  [NUM_BINS];
   logic [INSTR_BITS-1:0] instr_tally = '0;
   logic [CNT_BITS-1:0]   int_tally = '0;
   logic [CNT_BITS-1:0]   fp_tally = '0;
   logic                  seen_fp = 1'b0;
   logic                  seen_int = 1'b0;

   // Scoreboard and run control
   bin_update_t           expected_bin_updates [$];
   bin_update_t           oldest_update;
   stim_row_t             directed_rows [$];
   logic [REG_BITS-1:0]   reg_pool [POOL_SIZE];
   int                    mismatch_count = 0;
   int                    items_in_phase = 0;
   int                    send_idle_pct = 34;
   int                    recv_idle_pct = 86;
   int                    quiet_cycles = 0;

   register_dependency_distance_histogram u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_reg_id          (req_reg_id),
      .req_is_fp           (req_is_fp),
      .req_is_int          (req_is_int),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_dep_kind        (rsp_dep_kind),
      .rsp_dist_bin        (rsp_dist_bin),
      .rsp_bin_count       (rsp_bin_count),
      .rsp_instr_count     (rsp_instr_count),
      .rsp_int_instr_count (rsp_int_instr_count),
      .rsp_fp_instr_count  (rsp_fp_instr_count)
   );

   // Clock: period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predict the response to one accepted operand beat and advance the state
   function automatic bin_update_t predict_dependency(input operand_t op);
      bin_update_t           r;
      logic [STAMP_BITS-1:0] now;
      logic [STAMP_BITS-1:0] stamp;
      logic [STAMP_BITS-1:0] distance;
      logic [1:0]            bin;
      int                    slot;
      r = '0;
      now = instr_tally[STAMP_BITS-1:0];
      stamp = '0;
      if (op.mode == MODE_READ || op.mode == MODE_WRITE) begin
         if (op.is_fp) seen_fp = 1'b1;
         if (op.is_int) seen_int = 1'b1;
         if (op.mode == MODE_READ) begin
            if (wr_pending[op.reg_id]) begin
               r.dep_kind = DEP_RAW;
               stamp = wr_stamp[op.reg_id];
               wr_pending[op.reg_id] = 1'b0;
            end
            rd_pending[op.reg_id] = 1'b1;
            rd_stamp[op.reg_id] = now;
         end else begin
            // a pending read wins over a pending write
            if (rd_pending[op.reg_id]) begin
               r.dep_kind = DEP_WAR;
               stamp = rd_stamp[op.reg_id];
               rd_pending[op.reg_id] = 1'b0;
            end else if (wr_pending[op.reg_id]) begin
               r.dep_kind = DEP_WAW;
               stamp = wr_stamp[op.reg_id];
            end
            wr_pending[op.reg_id] = 1'b1;
            wr_stamp[op.reg_id] = now;
         end
      end else if (op.mode == MODE_END) begin
         if (seen_fp && fp_tally != '1) fp_tally++;
         if (seen_int && int_tally != '1) int_tally++;
         if (instr_tally != '1) instr_tally++;
         seen_fp = 1'b0;
         seen_int = 1'b0;
      end
      // bin the distance; edges are tested from the top down
      if (r.dep_kind != DEP_NONE) begin
         distance = now - stamp;
         if (distance > edge_high) bin = 2'd3;
         else if (distance > edge_mid) bin = 2'd2;
         else if (distance > edge_low) bin = 2'd1;
         else bin = 2'd0;
         slot = (int'(r.dep_kind) - 1) * 4 + int'(bin);
         if (bin_tally[slot] != '1) bin_tally[slot]++;
         r.dist_bin = bin;
         r.bin_count = bin_tally[slot];
      end
      r.instr_count = instr_tally;
      r.int_count = int_tally;
      r.fp_count = fp_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      mismatch_count++;
   endtask

   // Drive one operand beat and hold it until accepted
   task automatic send_operand(input operand_t op, input bit typed, input bin_update_t want);
      bin_update_t predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= op.mode;
      req_reg_id <= op.reg_id;
      req_is_fp  <= op.is_fp;
      req_is_int <= op.is_int;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_dependency(op);
      expected_bin_updates.push_back(typed ? want : predicted);
      items_in_phase++;
   endtask

   // Hold off the sender until every response is back; always waits on the clock, even when nothing is outstanding
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bin_updates.size() != 0);
   endtask

   // Program the low, mid and high edges, then poke the unused index, which must do nothing
   task automatic write_edges(input logic [EDGE_BITS-1:0] lo, input logic [EDGE_BITS-1:0] mid,
                              input logic [EDGE_BITS-1:0] hi);
      csr_write_en <= 1'b1;
      csr_index <= CSR_BIN_EDGE_LOW;
      csr_write_data <= lo;
      @(posedge clock);
      csr_index <= CSR_BIN_EDGE_MID;
      csr_write_data <= mid;
      @(posedge clock);
      csr_index <= CSR_BIN_EDGE_HIGH;
      csr_write_data <= hi;
      @(posedge clock);
      csr_index <= CSR_UNUSED_INDEX;
      csr_write_data <= EDGE_BITS'($urandom);
      @(posedge clock);
      csr_write_en <= 1'b0;
      edge_low = lo;
      edge_mid = mid;
      edge_high = hi;
   endtask

   function automatic stim_row_t row(input logic [1:0] mode, input logic [REG_BITS-1:0] rid,
                                     input logic fp, input logic in_int, input bit typed,
                                     input logic [1:0] kind, input logic [1:0] bin,
                                     input longint cnt, input longint instr,
                                     input longint intc, input longint fpc);
      stim_row_t s;
      s.op = '{mode: mode, reg_id: rid, is_fp: fp, is_int: in_int};
      s.typed = typed;
      s.want = '{dep_kind: kind, dist_bin: bin, bin_count: cnt[CNT_BITS-1:0],
                 instr_count: instr[INSTR_BITS-1:0], int_count: intc[CNT_BITS-1:0],
                 fp_count: fpc[CNT_BITS-1:0]};
      return s;
   endfunction

   // Register operand biased toward a few hot registers so dependencies are common
   function automatic operand_t random_operand(input logic [1:0] mode);
      operand_t op;
      int       roll;
      roll = $urandom_range(99);
      op.mode = mode;
      if (roll < 60) op.reg_id = reg_pool[$urandom_range(3)];
      else if (roll < 92) op.reg_id = reg_pool[$urandom_range(POOL_SIZE - 1)];
      else op.reg_id = REG_BITS'($urandom);
      op.is_fp = ($urandom_range(2) == 0);
      op.is_int = 1'($urandom_range(1));
      return op;
   endfunction

   // One well-formed instruction: reads, writes, end marker
   task automatic send_instruction();
      operand_t op;
      int       n_reads;
      int       n_writes;
      n_reads = $urandom_range(3);
      n_writes = $urandom_range(2);
      repeat (n_reads) send_operand(random_operand(MODE_READ), FROM_MODEL, '0);
      repeat (n_writes) send_operand(random_operand(MODE_WRITE), FROM_MODEL, '0);
      op = random_operand(MODE_END);
      send_operand(op, FROM_MODEL, '0);
   endtask

   // Response side: random backpressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bin_updates.size() == 0) begin
            report_mismatch("response beat with nothing expected", 64'(rsp_dep_kind), 0);
         end else begin
            oldest_update = expected_bin_updates.pop_front();
            if (rsp_dep_kind !== oldest_update.dep_kind)
               report_mismatch("dep_kind", 64'(rsp_dep_kind), 64'(oldest_update.dep_kind));
            if (rsp_dist_bin !== oldest_update.dist_bin)
               report_mismatch("dist_bin", 64'(rsp_dist_bin), 64'(oldest_update.dist_bin));
            if (rsp_bin_count !== oldest_update.bin_count)
               report_mismatch("bin_count", 64'(rsp_bin_count), 64'(oldest_update.bin_count));
            if (rsp_instr_count !== oldest_update.instr_count)
               report_mismatch("instr_count", 64'(rsp_instr_count),
                               64'(oldest_update.instr_count));
            if (rsp_int_instr_count !== oldest_update.int_count)
               report_mismatch("int_instr_count", 64'(rsp_int_instr_count),
                               64'(oldest_update.int_count));
            if (rsp_fp_instr_count !== oldest_update.fp_count)
               report_mismatch("fp_instr_count", 64'(rsp_fp_instr_count),
                               64'(oldest_update.fp_count));
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [EDGE_BITS-1:0] lo;
      logic [EDGE_BITS-1:0] mid;
      logic [EDGE_BITS-1:0] hi;
      bit                   held_once;
      for (int i = 0; i < NUM_REGS; i++) begin
         rd_pending[i] = 1'b0;
         wr_pending[i] = 1'b0;
         rd_stamp[i] = '0;
         wr_stamp[i] = '0;
      end
      for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;

      // Directed: reset edges, flags ignored at the end marker and in the unused mode,
      // each dependency kind, a distance past the mid edge
      directed_rows.push_back(row(MODE_END, 8'hFF, 1, 1, TYPED, DEP_NONE, 0, 0, 1, 0, 0));
      directed_rows.push_back(row(MODE_READ, 8'h00, 0, 1, TYPED, DEP_NONE, 0, 0, 1, 0, 0));
      directed_rows.push_back(row(MODE_WRITE, 8'h00, 0, 1, TYPED, DEP_WAR, 0, 1, 1, 0, 0));
      directed_rows.push_back(row(MODE_END, 8'h00, 0, 0, TYPED, DEP_NONE, 0, 0, 2, 1, 0));
      directed_rows.push_back(row(MODE_WRITE, 8'hFF, 1, 0, TYPED, DEP_NONE, 0, 0, 2, 1, 0));
      directed_rows.push_back(row(MODE_WRITE, 8'hFF, 1, 0, TYPED, DEP_WAW, 0, 1, 2, 1, 0));
      directed_rows.push_back(row(MODE_END, 8'h00, 0, 0, TYPED, DEP_NONE, 0, 0, 3, 1, 1));
      directed_rows.push_back(row(MODE_READ, 8'hFF, 0, 0, TYPED, DEP_RAW, 0, 1, 3, 1, 1));
      directed_rows.push_back(row(MODE_UNUSED, 8'hAA, 1, 1, TYPED, DEP_NONE, 0, 0, 3, 1, 1));
      directed_rows.push_back(row(MODE_END, 8'hAA, 1, 1, TYPED, DEP_NONE, 0, 0, 4, 1, 1));
      directed_rows.push_back(row(MODE_WRITE, 8'h00, 0, 1, FROM_MODEL, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(MODE_READ, 8'h00, 1, 0, FROM_MODEL, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(MODE_WRITE, 8'h55, 1, 1, FROM_MODEL, 0, 0, 0, 0, 0, 0));
      repeat (9) directed_rows.push_back(row(MODE_END, 8'h55, 0, 0, FROM_MODEL, 0, 0, 0,
                                             0, 0, 0));
      directed_rows.push_back(row(MODE_READ, 8'h55, 0, 1, FROM_MODEL, 0, 0, 0, 0, 0, 0));

      // Hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_operand(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

      // Random phases, each with its own edges and one of three idle patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_responses();
         case (p)
            0: begin lo = 8'd0; mid = 8'd0; hi = 8'd0; end
            1: begin lo = 8'd255; mid = 8'd255; hi = 8'd255; end
            2: begin lo = 8'd0; mid = 8'd1; hi = 8'd3; end
            3: begin lo = 8'd1; mid = 8'd4; hi = 8'd12; end
            4: begin lo = 8'd9; mid = 8'd3; hi = 8'd1; end
            default: begin
               lo = EDGE_BITS'($urandom_range(4));
               mid = lo + EDGE_BITS'($urandom_range(8));
               hi = mid + EDGE_BITS'($urandom_range(24));
            end
         endcase
         write_edges(lo, mid, hi);
         if (p < 2) begin
            send_idle_pct = 34;
            recv_idle_pct = 86;
         end else if (p < 4) begin
            send_idle_pct = 86;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         foreach (reg_pool[i]) reg_pool[i] = REG_BITS'($urandom);
         items_in_phase = 0;
         held_once = 1'b0;
         while (items_in_phase < ITEMS_PER_PHASE) begin
            if (!held_once && items_in_phase >= ITEMS_PER_PHASE / 2) begin
               drain_responses();
               held_once = 1'b1;
            end
            // mostly well-formed instructions, some stray beats of any mode
            if ($urandom_range(99) < 90) send_instruction();
            else send_operand(random_operand(2'($urandom_range(3))), FROM_MODEL, '0);
         end
      end

      // Wind down
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bin_updates.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
